[sv/swts_pkg.sv]
// Shared constants and control types for the sorted word table search block.
package swts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 11;
    localparam int SLOT_W      = 10;
    localparam int PART_W      = 40;
    localparam int KEY_W       = 3 * PART_W;

    localparam logic [COUNT_W-1:0] TABLE_DEPTH_C = COUNT_W'(TABLE_DEPTH);

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_we;
        logic start;
        logic step;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic done;
    } status_t;

endpackage

[sv/swts_ctrl.sv]
// Controller state machine for the sorted word table search.
module swts_ctrl
    import swts_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_req_type,
    output logic    s_ready,
    input  logic    m_ready,
    output logic    m_valid,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == REQ_LOAD) begin
                        cmd.load_we = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = status.empty ? ST_FINISH : ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                cmd.step = 1'b1;
                if (status.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // The result register must be free or emptying this cycle.
                if (!m_valid_reg || m_ready) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.fin) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

[sv/swts_dpath.sv]
// Datapath: table memory, count register, search window and key compare.
module swts_dpath
    import swts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic [SLOT_W-1:0]  s_slot_index,
    input  logic [PART_W-1:0]  s_key_bytes_head,
    input  logic [PART_W-1:0]  s_key_bytes_middle,
    input  logic [PART_W-1:0]  s_key_bytes_tail,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               m_found
);

    logic [KEY_W-1:0]   mem [TABLE_DEPTH];
    logic [KEY_W-1:0]   rdata_reg;
    logic [ADDR_W-1:0]  rd_addr;

    logic [COUNT_W-1:0] entry_count_reg;
    logic [COUNT_W-1:0] count_sat;
    logic [KEY_W-1:0]   key_reg;
    logic [COUNT_W-1:0] lo_reg;
    logic [COUNT_W-1:0] lo_next;
    logic [COUNT_W-1:0] hi_reg;
    logic [COUNT_W-1:0] hi_next;
    logic [COUNT_W-1:0] mid_reg;
    logic [COUNT_W-1:0] mid_next;
    logic [COUNT_W:0]   sum;
    logic               hit_reg;
    logic               found_reg;
    logic               key_lt;
    logic               key_eq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
        end else begin
            if (cfg_wr_en) begin
                entry_count_reg <= cfg_wr_data;
            end
            if (cmd.start) begin
                lo_reg <= '0;
                hi_reg <= count_sat;
            end else if (cmd.step && !key_eq) begin
                lo_reg <= lo_next;
                hi_reg <= hi_next;
            end
        end
    end

    assign count_sat = (entry_count_reg > TABLE_DEPTH_C) ? TABLE_DEPTH_C : entry_count_reg;

    // Each cycle of the search compares the word read at the midpoint and
    // issues the read of the next midpoint.
    assign key_lt = key_reg < rdata_reg;
    assign key_eq = key_reg == rdata_reg;

    always_comb begin
        if (key_lt) begin
            lo_next = lo_reg;
            hi_next = mid_reg;
        end else begin
            lo_next = mid_reg + COUNT_W'(1);
            hi_next = hi_reg;
        end
        sum      = {1'b0, lo_next} + {1'b0, hi_next};
        mid_next = sum[COUNT_W:1];
        if (cmd.start) begin
            rd_addr = ADDR_W'(count_sat >> 1);
        end else begin
            rd_addr = mid_next[ADDR_W-1:0];
        end
        status.empty = (count_sat == '0);
        status.done  = key_eq || (lo_next >= hi_next);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_we && ({1'b0, s_slot_index} < TABLE_DEPTH_C)) begin
            mem[s_slot_index[ADDR_W-1:0]] <= {s_key_bytes_head, s_key_bytes_middle,
                                              s_key_bytes_tail};
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg <= {s_key_bytes_head, s_key_bytes_middle, s_key_bytes_tail};
            mid_reg <= count_sat >> 1;
            hit_reg <= 1'b0;
        end else if (cmd.step) begin
            mid_reg <= mid_next;
            if (key_eq) begin
                hit_reg <= 1'b1;
            end
        end
        if (cmd.fin) begin
            found_reg <= hit_reg;
        end
    end

    assign m_found = found_reg;

endmodule

[sv/sorted_word_table_search_top.sv]
// Top level of the sorted word table search block.
//
// The block holds a table of up to 1024 words of 15 bytes each, loaded by
// the user in ascending byte order, and answers whether a key is present.
// Every input word carries a request type. A load word writes its three
// 40-bit key parts into the entry given by s_slot_index in the cycle it is
// accepted and produces no result; a slot beyond the table is dropped.
// A search word runs a binary search over the first entry_count entries.
// The user writes entry_count through cfg_wr_en and cfg_wr_data only
// while idle; the block itself does not enforce this. The search loop
// reads one table entry per cycle from a single read port: a start step
// that issues the first read, then one compare per probe, at most
// ceil(log2(entry_count + 1)) probes (eleven for a full table), and a
// finish step that hands the answer to the result register. An empty
// table skips the probes. Loads are taken back to back, one per cycle.
// The one-bit result sits in an output register; the block accepts new
// words while it waits. If the receiver stalls with a result still held,
// a finished search waits until the register frees up.
// After reset the count is zero, no result is pending, and the block is
// ready; table contents are undefined until loaded.
module sorted_word_table_search_top
    import swts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [SLOT_W-1:0]  s_slot_index,
    input  logic [PART_W-1:0]  s_key_bytes_head,
    input  logic [PART_W-1:0]  s_key_bytes_middle,
    input  logic [PART_W-1:0]  s_key_bytes_tail,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found
);

    cmd_t    cmd;
    status_t status;

    // The controller sequences each word; the datapath owns all storage.
    swts_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .status     (status),
        .cmd        (cmd)
    );

    swts_dpath u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_slot_index       (s_slot_index),
        .s_key_bytes_head   (s_key_bytes_head),
        .s_key_bytes_middle (s_key_bytes_middle),
        .s_key_bytes_tail   (s_key_bytes_tail),
        .cmd                (cmd),
        .status             (status),
        .m_found            (m_found)
    );

endmodule

[sv/swts_chk.sv]
// Port-level checker for the sorted word table search, bound to the top level.
module swts_chk
    import swts_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_req_type,
    input logic m_valid,
    input logic m_ready,
    input logic m_found
);

    // A held result stays offered until it is taken.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_found))
        else $error("result word changed while stalled");

    // Coming out of reset nothing is pending and the input side is open.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // An accepted search keeps the block busy for at least the next cycle.
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type == REQ_SEARCH |=> !s_ready)
        else $error("input taken while a search is starting");

endmodule

bind sorted_word_table_search_top swts_chk u_swts_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_req_type (s_req_type),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_found    (m_found)
);

[dv/tb_sorted_word_table_search_top.sv]
// Self-checking testbench for the sorted word table search block.
module tb_sorted_word_table_search_top
    import swts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block.
    // ------------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_req_type;
    logic [SLOT_W-1:0]  s_slot_index;
    logic [PART_W-1:0]  s_key_bytes_head;
    logic [PART_W-1:0]  s_key_bytes_middle;
    logic [PART_W-1:0]  s_key_bytes_tail;
    logic               m_valid;
    logic               m_ready;
    logic               m_found;

    sorted_word_table_search_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_slot_index       (s_slot_index),
        .s_key_bytes_head   (s_key_bytes_head),
        .s_key_bytes_middle (s_key_bytes_middle),
        .s_key_bytes_tail   (s_key_bytes_tail),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_found            (m_found)
    );

    // The clock runs with a 4 ns period, two ns high and two ns low.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Shadow state of the block and bookkeeping.
    // ------------------------------------------------------------------
    // The table is held as whole 120-bit keys, head part in the top bits, so
    // that a plain unsigned compare orders keys exactly as the byte-wise
    // compare with the first byte most significant does.
    logic [KEY_W-1:0]   word_store [TABLE_DEPTH];
    logic [COUNT_W-1:0] entry_count_shadow;
    logic               pending_found [$];
    logic               want_found;

    int  errors;
    int  n_loads;
    int  n_searches;
    int  n_checked;
    int  n_settings;
    // When this is clear, neither the sender nor the receiver inserts gaps.
    bit  idle_en;
    int  stall_left;

    // ------------------------------------------------------------------
    // Prediction.
    // ------------------------------------------------------------------
    // Counts above the table depth are clamped to the full table.
    function automatic int active_span();
        if (entry_count_shadow > TABLE_DEPTH_C) begin
            return TABLE_DEPTH;
        end
        return int'(entry_count_shadow);
    endfunction

    // Binary search over the entries in use. The probes are the same whether
    // or not the table is sorted, so an unsorted table is answered by the
    // very same walk.
    function automatic logic search_table(input logic [KEY_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = active_span();
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (key < word_store[ADDR_W'(mid)]) begin
                hi = mid;
            end else if (key > word_store[ADDR_W'(mid)]) begin
                lo = mid + 1;
            end else begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return r[KEY_W-1:0];
    endfunction

    // Picks a search key for a table of the given span: mostly keys that are
    // present, then near misses one above or below a present key, keys that
    // share only the head part with a present key, and wholly random keys.
    function automatic logic [KEY_W-1:0] probe_key(input int span);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] hit;
        int               pick;
        k = rand_key();
        if (span > 0) begin
            hit  = word_store[ADDR_W'($urandom_range(0, span - 1))];
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                k = hit;
            end else if (pick < 7) begin
                k = hit + 1'b1;
            end else if (pick < 8) begin
                k = hit - 1'b1;
            end else if (pick < 9) begin
                k = {hit[KEY_W-1 -: PART_W], k[2*PART_W-1:0]};
            end
        end
        return k;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Input side: one word per call, held until the block takes it.
    // ------------------------------------------------------------------
    // Valid is only lowered when a gap starts or when the sender pauses, so
    // a word that follows straight on keeps valid high with no glitch.
    task automatic send_word(input logic kind, input logic [SLOT_W-1:0] slot,
                             input logic [KEY_W-1:0] key);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_req_type         <= kind;
        s_slot_index       <= slot;
        s_key_bytes_head   <= key[KEY_W-1 -: PART_W];
        s_key_bytes_middle <= key[2*PART_W-1 -: PART_W];
        s_key_bytes_tail   <= key[PART_W-1:0];
        do begin
            @(posedge aclk);
        end while (!s_ready);
        // The word was taken at this edge; update the shadow table or queue
        // the answer that the search must give.
        if (kind == REQ_LOAD) begin
            word_store[slot] = key;
            n_loads++;
        end else begin
            pending_found.push_back(search_table(key));
            n_searches++;
        end
    endtask

    task automatic send_search(input logic [KEY_W-1:0] key);
        send_word(REQ_SEARCH, SLOT_W'($urandom), key);
    endtask

    // Stops sending and waits until every outstanding search has answered.
    task automatic wait_for_answers();
        s_valid <= 1'b0;
        while (pending_found.size() != 0) @(posedge aclk);
    endtask

    // The count is only changed with the block idle. Loads leave nothing in
    // the answer queue; the task waits for it to drain, then pauses further.
    task automatic set_entry_count(input int value);
        wait_for_answers();
        repeat (16) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(value);
        @(posedge aclk);
        cfg_wr_en          <= 1'b0;
        entry_count_shadow  = COUNT_W'(value);
        n_settings++;
    endtask

    // Loads slots 0 to n-1 in a shuffled order. The keys rise with random
    // gaps that are sometimes zero (duplicates) or tiny (neighbor keys);
    // with scramble set they are random and the table ends up unsorted.
    task automatic load_table(input int n, input bit scramble);
        logic [KEY_W-1:0] keys [TABLE_DEPTH];
        int               order [TABLE_DEPTH];
        logic [KEY_W-1:0] acc;
        logic [127:0]     r;
        int               j;
        int               tmp;
        acc = rand_key() >> 12;
        for (int i = 0; i < n; i++) begin
            r = {$urandom, $urandom, $urandom, $urandom};
            case ($urandom_range(0, 7))
                0:       acc = acc;
                1:       acc = acc + KEY_W'($urandom_range(1, 3));
                default: acc = acc + KEY_W'(r >> 19);
            endcase
            keys[ADDR_W'(i)]  = scramble ? rand_key() : acc;
            order[ADDR_W'(i)] = i;
        end
        for (int i = n - 1; i > 0; i--) begin
            j                 = $urandom_range(0, i);
            tmp               = order[ADDR_W'(i)];
            order[ADDR_W'(i)] = order[ADDR_W'(j)];
            order[ADDR_W'(j)] = tmp;
        end
        for (int i = 0; i < n; i++) begin
            send_word(REQ_LOAD, SLOT_W'(order[ADDR_W'(i)]),
                      keys[ADDR_W'(order[ADDR_W'(i)])]);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random receiver stalls and the answer check.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (idle_en && stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11);
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Each answer is matched against the oldest search still waiting.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_found.size() == 0) begin
                report_mismatch($sformatf("answer found=%0b with no search waiting", m_found));
            end else begin
                want_found = pending_found.pop_front();
                n_checked++;
                if (m_found !== want_found) begin
                    report_mismatch($sformatf("search %0d: found=%0b, should be %0b",
                                              n_checked, m_found, want_found));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // Right after reset the count is zero, so any key must miss. The same
    // holds after an explicit write of zero.
    task automatic test_empty_table();
        send_search({KEY_W{1'b0}});
        send_search({KEY_W{1'b1}});
        set_entry_count(0);
        send_search(rand_key());
    endtask

    // A five-entry table whose keys, but for the all-ones top entry, each
    // set at most one part, so that head, middle and tail each decide some
    // compare. Hits on every entry and misses between entries, then a
    // one-entry table.
    task automatic test_part_ordering();
        logic [PART_W-1:0] z;
        logic [PART_W-1:0] o;
        z = '0;
        o = '1;
        send_word(REQ_LOAD, 10'd3, {PART_W'(1), z, z});
        send_word(REQ_LOAD, 10'd0, {z, z, z});
        send_word(REQ_LOAD, 10'd4, {o, o, o});
        send_word(REQ_LOAD, 10'd2, {z, PART_W'(1), z});
        send_word(REQ_LOAD, 10'd1, {z, z, PART_W'(1)});
        set_entry_count(5);
        for (int i = 0; i < 5; i++) begin
            send_search(word_store[ADDR_W'(i)]);
        end
        send_search({z, z, PART_W'(2)});
        send_search({z, PART_W'(1), PART_W'(1)});
        send_search({o, o, o - 1'b1});
        send_search({PART_W'(1), z, o});
        set_entry_count(1);
        send_search({z, z, z});
        send_search({o, o, o});
    endtask

    // Fills the whole table in sorted order, then searches it with the
    // count at the depth, saturated above it, one short of it, and at a
    // random size.
    task automatic test_full_table();
        load_table(TABLE_DEPTH, 1'b0);
        set_entry_count(TABLE_DEPTH);
        repeat (40) send_search(probe_key(active_span()));
        set_entry_count((1 << COUNT_W) - 1);
        repeat (25) send_search(probe_key(active_span()));
        set_entry_count(TABLE_DEPTH - 1);
        repeat (20) send_search(probe_key(active_span()));
        set_entry_count($urandom_range(2, TABLE_DEPTH - 2));
        repeat (20) send_search(probe_key(active_span()));
    endtask

    // Rounds of a fresh small table at the bottom of the store, a count
    // that mostly matches it, and searches with the odd load mixed in. All
    // entries were written by the full-table test, so any count is legal.
    task automatic test_random_tables(input int word_budget);
        int n;
        int cnt;
        int slot;
        while (n_loads + n_searches < word_budget) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 160)
                                              : $urandom_range(1, 32);
            load_table(n, $urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0:       cnt = 0;
                1:       cnt = $urandom_range(0, n);
                2:       cnt = $urandom_range(n, TABLE_DEPTH);
                3:       cnt = TABLE_DEPTH;
                4:       cnt = $urandom_range(TABLE_DEPTH + 1, (1 << COUNT_W) - 1);
                default: cnt = n;
            endcase
            set_entry_count(cnt);
            repeat ($urandom_range(8, 30)) begin
                if ($urandom_range(0, 9) == 0) begin
                    slot = $urandom_range(0, TABLE_DEPTH - 1);
                    send_word(REQ_LOAD, SLOT_W'(slot),
                              ($urandom_range(0, 1) == 0) ? word_store[ADDR_W'(slot)]
                                                          : rand_key());
                end else begin
                    send_search(probe_key(active_span()));
                end
            end
        end
    endtask

    // Traffic with no gaps on either side: full-table searches, the longest
    // ones the block runs, with loads in between.
    task automatic test_back_to_back();
        int slot;
        idle_en = 1'b0;
        set_entry_count(TABLE_DEPTH);
        repeat (110) begin
            if ($urandom_range(0, 5) == 0) begin
                slot = $urandom_range(0, TABLE_DEPTH - 1);
                send_word(REQ_LOAD, SLOT_W'(slot), word_store[ADDR_W'(slot)]);
            end else begin
                send_search(probe_key(active_span()));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial begin
        n_loads            = 0;
        n_searches         = 0;
        n_settings         = 0;
        idle_en            = 1'b1;
        entry_count_shadow = '0;
        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        s_valid            = 1'b0;
        s_req_type         = REQ_LOAD;
        s_slot_index       = '0;
        s_key_bytes_head   = '0;
        s_key_bytes_middle = '0;
        s_key_bytes_tail   = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_part_ordering();
        test_full_table();
        test_random_tables(1340);
        test_back_to_back();

        wait_for_answers();
        repeat (20) @(posedge aclk);

        $display("Covered %0d loads and %0d searches over %0d count settings,",
                 n_loads, n_searches, n_settings);
        $display("from an empty table to a saturated full one; %0d answers checked.",
                 n_checked);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this time.
    initial begin
        #2ms;
        $display("Timeout with %0d searches still unanswered.", pending_found.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
